/* design/swm_pkg.sv */
// shared types and constants for the sliding window median filter
package swm_pkg;

  // largest window the cell row can hold
  localparam int WINDOW_MAX = 64;
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
  localparam int POS_W      = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int SAMPLE_W   = 32;
  localparam int WSIZE_W    = 7;
  localparam int COUNT_W    = 32;

  // commands broadcast to the cell row
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } swm_in_t;

  // result word
  typedef struct packed {
    logic signed [SAMPLE_W:0] median_x2;
    logic [COUNT_W-1:0]       result_count;
  } swm_out_t;

  // broadcast command: delete value x or insert value v
  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] v;
  } swm_cmd_t;

  // per-cell occupancy flags
  typedef struct packed {
    logic valid;
    logic at_end;
  } swm_cell_ctl_t;

endpackage

/* design/swm_ram.sv */
// generic single-port-write ram with registered read
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/swm_cell.sv */
// one cell of the sorted row: holds a value, shifts down on delete, up on insert
module swm_cell import swm_pkg::*; (
  input  logic                       clk,
  input  swm_cmd_t                   cmd,
  input  swm_cell_ctl_t              ctl,
  input  logic signed [SAMPLE_W-1:0] left_val,
  input  logic                       left_gt,
  input  logic signed [SAMPLE_W-1:0] right_val,
  input  logic                       right_eqx,
  output logic signed [SAMPLE_W-1:0] val_o,
  output logic                       gt_o,
  output logic                       eqx_o
);

  logic signed [SAMPLE_W-1:0] val_r;
  logic signed [SAMPLE_W-1:0] val_nxt;
  logic                       shift_dn;

  // neighbor flags
  assign gt_o  = ctl.valid && (val_r > cmd.v);
  assign eqx_o = ctl.valid && (val_r == cmd.x);

  // delete takes out the last cell equal to x, so cells above it move down
  assign shift_dn = ctl.valid && ((val_r > cmd.x) || ((val_r == cmd.x) && !right_eqx));

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      OP_HOLD: begin
        val_nxt = val_r;
      end
      OP_DEL: begin
        if (shift_dn) begin
          val_nxt = right_val;
        end
      end
      OP_INS: begin
        if (gt_o || ctl.at_end) begin
          val_nxt = left_gt ? left_val : cmd.v;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

/* design/sliding_window_median.sv */
// sliding window median: arrival ring in ram, sorted copy in a row of cells
// result word: registered in the median pick, which waits while out_stall holds
// steps: ring read, delete pass, insert pass, median pick; no new word until done
// the delete and insert passes run through the cell row
// reset: control state cleared and window size set to 3; ring and cells are not cleared
module sliding_window_median import swm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  swm_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output swm_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WSIZE_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [WSIZE_W-1:0]         wsize_r, wsize_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [POS_W-1:0]           wpos_r, wpos_nxt;
  logic [COUNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic                       out_valid_r, out_valid_nxt;
  swm_out_t                   out_r, out_nxt;

  logic                       in_acc;
  logic                       cfg_acc;
  logic [FILL_W-1:0]          k_act;
  logic [FILL_W-1:0]          wpos_inc;
  logic [FILL_W-1:0]          lo_idx, hi_idx;
  logic signed [SAMPLE_W-1:0] med_lo, med_hi;
  logic [COUNT_W-1:0]         cnt_inc;
  logic                       ram_we;
  logic [POS_W-1:0]           ram_raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  swm_cmd_t                   cmd;

  logic signed [SAMPLE_W-1:0] cell_val [WINDOW_MAX];
  logic                       cell_gt  [WINDOW_MAX];
  logic                       cell_eqx [WINDOW_MAX];

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // effective window size
  always_comb begin
    if (wsize_r == '0) begin
      k_act = FILL_W'(1);
    end else if (int'(wsize_r) > WINDOW_MAX) begin
      k_act = FILL_W'(WINDOW_MAX);
    end else begin
      k_act = FILL_W'(wsize_r);
    end
  end

  assign wpos_inc = FILL_W'(wpos_r) + FILL_W'(1);
  assign lo_idx   = (k_act - FILL_W'(1)) >> 1;
  assign hi_idx   = k_act >> 1;
  assign med_lo   = cell_val[lo_idx[POS_W-1:0]];
  assign med_hi   = cell_val[hi_idx[POS_W-1:0]];
  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_W'(1);

  // ring read of the oldest sample, write of the new one
  assign ram_raddr = in_data.restart ? '0 : wpos_r;
  assign ram_we    = (state_r == ST_DEL);

  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (v_r),
    .re    (in_acc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command to the cell row
  always_comb begin
    cmd.op = OP_HOLD;
    cmd.x  = $signed(ram_rdata);
    cmd.v  = v_r;
    if ((state_r == ST_DEL) && (fill_r >= k_act)) begin
      cmd.op = OP_DEL;
    end else if (state_r == ST_INS) begin
      cmd.op = OP_INS;
    end
  end

  // sorted cell row
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell_ctl_t              ctl;
    logic signed [SAMPLE_W-1:0] left_val, right_val;
    logic                       left_gt, right_eqx;

    assign ctl.valid  = (FILL_W'(i) < fill_r);
    assign ctl.at_end = (FILL_W'(i) == fill_r);

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
      assign right_eqx = 1'b0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
      assign right_eqx = cell_eqx[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ctl       (ctl),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .right_eqx (right_eqx),
      .val_o     (cell_val[i]),
      .gt_o      (cell_gt[i]),
      .eqx_o     (cell_eqx[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wsize_nxt     = wsize_r;
    fill_nxt      = fill_r;
    wpos_nxt      = wpos_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt     = in_data.sample;
          state_nxt = ST_DEL;
          if (in_data.restart) begin
            fill_nxt = '0;
            wpos_nxt = '0;
            cnt_nxt  = '0;
          end
        end
      end
      ST_DEL: begin
        if (fill_r >= k_act) begin
          fill_nxt = fill_r - FILL_W'(1);
        end
        wpos_nxt  = (wpos_inc == k_act) ? '0 : wpos_inc[POS_W-1:0];
        state_nxt = ST_INS;
      end
      ST_INS: begin
        fill_nxt  = fill_r + FILL_W'(1);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (fill_r != k_act) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_nxt.median_x2    = {med_lo[SAMPLE_W-1], med_lo} + {med_hi[SAMPLE_W-1], med_hi};
          out_nxt.result_count = cnt_inc;
          out_valid_nxt        = 1'b1;
          cnt_nxt              = cnt_inc;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write clears the window
    if (cfg_acc) begin
      wsize_nxt = cfg_data;
      fill_nxt  = '0;
      wpos_nxt  = '0;
      cnt_nxt   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wsize_r     <= WSIZE_W'(3);
      fill_r      <= '0;
      wpos_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wsize_r     <= wsize_nxt;
      fill_r      <= fill_nxt;
      wpos_r      <= wpos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
